### src/vna_pkg.sv
package vna_pkg;

   // request codes
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_FACE  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam int ACC_BITS  = 40;
   localparam int OUT_BITS  = 16;
   localparam int MAG_BITS  = 31;
   localparam int Q_BITS    = 15;
   localparam int LEN_BITS  = 32;
   localparam int NUM_BITS  = 46;
   localparam int FRAC_BITS = 14;

   typedef logic signed [ACC_BITS-1:0] acc_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] x;
      logic signed [OUT_BITS-1:0] y;
      logic signed [OUT_BITS-1:0] z;
   } normal_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FB,
      ST_FC,
      ST_DIFF,
      ST_MUL,
      ST_SUB,
      ST_ARD,
      ST_AWR,
      ST_RCHK,
      ST_NORM,
      ST_OUT
   } top_state_type;

   typedef enum logic [2:0] {
      N_IDLE,
      N_MAG,
      N_SHIFT,
      N_SQ,
      N_SQRT,
      N_DSET,
      N_DIV,
      N_DONE
   } norm_state_type;

endpackage

### src/vna_norm.sv
module vna_norm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  vna_pkg::acc_type     acc_x,
   input  vna_pkg::acc_type     acc_y,
   input  vna_pkg::acc_type     acc_z,
   output logic                 done,
   output vna_pkg::normal_type  result
);

   localparam int AB = vna_pkg::ACC_BITS;
   localparam int MB = vna_pkg::MAG_BITS;
   localparam int QB = vna_pkg::Q_BITS;
   localparam int LB = vna_pkg::LEN_BITS;
   localparam int NB = vna_pkg::NUM_BITS;
   localparam int FB = vna_pkg::FRAC_BITS;
   localparam int OB = vna_pkg::OUT_BITS;

   vna_pkg::norm_state_type st_ff, st_in;

   logic [AB-1:0]   mag_ff [3];
   logic [AB-1:0]   mag_in [3];
   logic            neg_ff [3];
   logic            neg_in [3];
   logic [AB-1:0]   max_ff, max_in;
   logic [1:0]      k_ff, k_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic [2*MB-1:0] sq_ff, sq_in;
   logic [63:0]     s_ff, s_in;
   logic [63:0]     r_ff, r_in;
   logic [63:0]     bit_ff, bit_in;
   logic [LB-1:0]   len_ff, len_in;
   logic [LB-1:0]   rem_ff, rem_in;
   logic [QB-1:0]   low_ff, low_in;
   logic [QB-1:0]   q_ff [3];
   logic [QB-1:0]   q_in [3];

   logic [MB-1:0]   mk;
   logic [63:0]     t;
   logic [NB-1:0]   num;
   logic [LB:0]     rem2;
   logic            ge;
   logic [OB-1:0]   qe [3];
   logic [OB-1:0]   sv [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= vna_pkg::N_IDLE;
      end else begin
         st_ff <= st_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      max_ff <= max_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      sq_ff  <= sq_in;
      s_ff   <= s_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      len_ff <= len_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   always_comb begin
      st_in  = st_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      max_in = max_ff;
      k_in   = k_ff;
      cnt_in = cnt_ff;
      sq_in  = sq_ff;
      s_in   = s_ff;
      r_in   = r_ff;
      bit_in = bit_ff;
      len_in = len_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      q_in   = q_ff;

      case (k_ff)
         2'd0:    mk = mag_ff[0][MB-1:0];
         2'd1:    mk = mag_ff[1][MB-1:0];
         default: mk = mag_ff[2][MB-1:0];
      endcase
      t    = r_ff + bit_ff;
      num  = NB'({mk, {FB{1'b0}}}) + NB'(len_ff[LB-1:1]);
      rem2 = {rem_ff, low_ff[QB-1]};
      ge   = rem2 >= {1'b0, len_ff};

      unique case (st_ff)
         vna_pkg::N_IDLE: begin
            if (start) begin
               neg_in[0] = acc_x[AB-1];
               neg_in[1] = acc_y[AB-1];
               neg_in[2] = acc_z[AB-1];
               mag_in[0] = acc_x[AB-1] ? (~acc_x + 1'b1) : acc_x;
               mag_in[1] = acc_y[AB-1] ? (~acc_y + 1'b1) : acc_y;
               mag_in[2] = acc_z[AB-1] ? (~acc_z + 1'b1) : acc_z;
               st_in = vna_pkg::N_MAG;
            end
         end
         vna_pkg::N_MAG: begin
            max_in = mag_ff[0];
            if (mag_ff[1] > max_in) max_in = mag_ff[1];
            if (mag_ff[2] > max_in) max_in = mag_ff[2];
            st_in = vna_pkg::N_SHIFT;
         end
         vna_pkg::N_SHIFT: begin
            // one bit a cycle until the largest magnitude sits in [2^30, 2^31)
            if (max_ff[AB-1:MB] != '0) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
               max_in = max_ff >> 1;
            end else if (!max_ff[MB-1]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
               max_in = max_ff << 1;
            end else begin
               k_in  = 2'd0;
               s_in  = '0;
               st_in = vna_pkg::N_SQ;
            end
         end
         vna_pkg::N_SQ: begin
            sq_in = {{MB{1'b0}}, mk} * {{MB{1'b0}}, mk};
            if (k_ff != 2'd0) s_in = s_ff + 64'(sq_ff);
            if (k_ff == 2'd3) begin
               r_in   = '0;
               bit_in = 64'd1 << 62;
               st_in  = vna_pkg::N_SQRT;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         vna_pkg::N_SQRT: begin
            if (s_ff >= t) begin
               s_in = s_ff - t;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) begin
               // root is final here, so every dividend sees the new length
               len_in = r_in[LB-1:0];
               k_in   = 2'd0;
               st_in  = vna_pkg::N_DSET;
            end
         end
         vna_pkg::N_DSET: begin
            rem_in = LB'(num[NB-1:QB]);
            low_in = num[QB-1:0];
            cnt_in = '0;
            st_in  = vna_pkg::N_DIV;
         end
         vna_pkg::N_DIV: begin
            rem_in = ge ? LB'(rem2 - {1'b0, len_ff}) : rem2[LB-1:0];
            low_in = low_ff << 1;
            q_in[k_ff] = {q_ff[k_ff][QB-2:0], ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(QB-1)) begin
               if (k_ff == 2'd2) begin
                  st_in = vna_pkg::N_DONE;
               end else begin
                  k_in  = k_ff + 2'd1;
                  st_in = vna_pkg::N_DSET;
               end
            end
         end
         vna_pkg::N_DONE: begin
            st_in = vna_pkg::N_IDLE;
         end
         default: st_in = vna_pkg::N_IDLE;
      endcase
   end

   // sign of each accumulator back on its quotient
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qe[i] = {1'b0, q_ff[i]};
         sv[i] = neg_ff[i] ? (~qe[i] + 1'b1) : qe[i];
      end
   end

   assign done     = (st_ff == vna_pkg::N_DONE);
   assign result.x = sv[0];
   assign result.y = sv[1];
   assign result.z = sv[2];

endmodule

### src/mesh_vertex_normal_accumulator_unit.sv
// area-weighted vertex normal accumulator
// req channel (req_valid / req_stall) carries one item: req_type selects a
// vertex write (position stored, accumulator of that vertex cleared), a face
// add (cross product of the corner edges added to all three corner
// accumulators, saturating at 40 bits) or a normal read. code 3 is dropped.
// only a read gives a result on the rsp channel (rsp_valid / rsp_stall):
// the unit-length normal in Q1.14, or zero with rsp_degenerate set when the
// accumulator is exactly zero or the index is out of range.
// a vertex write completes in the idle state. a face takes three position
// reads, three product pairs each with a subtract and three accumulator
// read-modify-writes on one port each. a read runs the normalizer: a one-bit
// shifter of up to 30 steps, a 32-step square root and three 15-step
// divisions, all sequential. a read of a zero accumulator or of an
// out-of-range index skips the normalizer; an ignored face or code 3 is dropped.
// one item is in work at a time; req_stall is high while busy.
// after reset the accumulator memory is swept to zero, one entry per cycle,
// over all MAX_VERTICES entries, with req_stall high.
// a finished result waits in the rsp register while rsp_stall is high; the
// next item is taken meanwhile, and a later read waits for the register.
module mesh_vertex_normal_accumulator_unit #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [9:0]         req_vertex_index,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic [9:0]         req_corner_a,
   input  logic [9:0]         req_corner_b,
   input  logic [9:0]         req_corner_c,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic               rsp_degenerate
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = COORD_BITS;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int NW = PW + 1;
   localparam int AB = vna_pkg::ACC_BITS;
   localparam int SW = ((NW > AB) ? NW : AB) + 1;
   localparam logic signed [SW-1:0] ACC_HI = {{(SW-AB+1){1'b0}}, {(AB-1){1'b1}}};
   localparam logic signed [SW-1:0] ACC_LO = {{(SW-AB+1){1'b1}}, {(AB-1){1'b0}}};

   // memories
   logic [3*CW-1:0] pos_mem [MAX_VERTICES];
   logic [3*AB-1:0] acc_mem [MAX_VERTICES];
   logic [3*CW-1:0] pos_rd_ff;
   logic [3*AB-1:0] acc_rd_ff;

   logic            pos_we;
   logic [AW-1:0]   pos_waddr, pos_raddr;
   logic [3*CW-1:0] pos_wdata;
   logic            acc_we;
   logic [AW-1:0]   acc_waddr, acc_raddr;
   logic [3*AB-1:0] acc_wdata;

   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
      acc_rd_ff <= acc_mem[acc_raddr];
   end

   // control and datapath registers
   vna_pkg::top_state_type state_ff, state_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [AW-1:0]         cor_ff [3];
   logic [AW-1:0]         cor_in [3];
   logic [1:0]            sel_ff, sel_in;
   logic [3*CW-1:0]       pa_ff, pa_in;
   logic [3*CW-1:0]       pb_ff, pb_in;
   logic signed [DW-1:0]  u_ff [3];
   logic signed [DW-1:0]  u_in [3];
   logic signed [DW-1:0]  v_ff [3];
   logic signed [DW-1:0]  v_in [3];
   logic signed [PW-1:0]  p1_ff, p1_in;
   logic signed [PW-1:0]  p2_ff, p2_in;
   logic signed [NW-1:0]  n_ff [3];
   logic signed [NW-1:0]  n_in [3];
   vna_pkg::normal_type   pend_ff, pend_in;
   logic                  pend_deg_ff, pend_deg_in;
   vna_pkg::normal_type   res_ff, res_in;
   logic                  res_deg_ff, res_deg_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic [31:0]           vi32, ca32, cb32, cc32;
   logic                  vi_ok, face_ok;
   logic [3*CW-1:0]       wr_pos;
   logic [1:0]            mi, mj;
   logic signed [SW-1:0]  sum [3];
   logic signed [AB-1:0]  sat [3];
   logic                  norm_start, norm_done;
   vna_pkg::normal_type   norm_res;

   vna_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .acc_x  (acc_rd_ff[0*AB +: AB]),
      .acc_y  (acc_rd_ff[1*AB +: AB]),
      .acc_z  (acc_rd_ff[2*AB +: AB]),
      .done   (norm_done),
      .result (norm_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vna_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cor_ff      <= cor_in;
      sel_ff      <= sel_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      n_ff        <= n_in;
      pend_ff     <= pend_in;
      pend_deg_ff <= pend_deg_in;
      res_ff      <= res_in;
      res_deg_ff  <= res_deg_in;
   end

   // field decode; coordinates keep their low COORD_BITS bits
   always_comb begin
      logic [31:0] rx, ry, rz;
      rx = {16'b0, req_pos_x};
      ry = {16'b0, req_pos_y};
      rz = {16'b0, req_pos_z};
      wr_pos = {rz[CW-1:0], ry[CW-1:0], rx[CW-1:0]};
   end

   assign vi32    = 32'(req_vertex_index);
   assign ca32    = 32'(req_corner_a);
   assign cb32    = 32'(req_corner_b);
   assign cc32    = 32'(req_corner_c);
   assign vi_ok   = vi32 < 32'(MAX_VERTICES);
   assign face_ok = (ca32 < 32'(MAX_VERTICES)) && (cb32 < 32'(MAX_VERTICES)) &&
                    (cc32 < 32'(MAX_VERTICES));

   assign req_stall = (state_ff != vna_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // cross product operand pairing: n[k] = u[i]*v[j] - u[j]*v[i]
   always_comb begin
      case (sel_ff)
         2'd0:    begin mi = 2'd1; mj = 2'd2; end
         2'd1:    begin mi = 2'd2; mj = 2'd0; end
         default: begin mi = 2'd0; mj = 2'd1; end
      endcase
   end

   // saturating accumulate, three independent lanes
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum[k] = SW'($signed(acc_rd_ff[k*AB +: AB])) + SW'(n_ff[k]);
         if (sum[k] > ACC_HI)      sat[k] = AB'(ACC_HI);
         else if (sum[k] < ACC_LO) sat[k] = AB'(ACC_LO);
         else                      sat[k] = AB'(sum[k]);
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cor_in      = cor_ff;
      sel_in      = sel_ff;
      pa_in       = pa_ff;
      pb_in       = pb_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      p1_in       = p1_ff;
      p2_in       = p2_ff;
      n_in        = n_ff;
      pend_in     = pend_ff;
      pend_deg_in = pend_deg_ff;
      res_in      = res_ff;
      res_deg_in  = res_deg_ff;
      norm_start  = 1'b0;

      pos_we    = 1'b0;
      pos_waddr = vi32[AW-1:0];
      pos_wdata = wr_pos;
      pos_raddr = ca32[AW-1:0];
      acc_we    = 1'b0;
      acc_waddr = cor_ff[sel_ff];
      acc_wdata = {sat[2], sat[1], sat[0]};
      acc_raddr = vi32[AW-1:0];

      // output register drains whenever the receiver takes the item
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         vna_pkg::ST_CLEAR: begin
            acc_we    = 1'b1;
            acc_waddr = clr_ff;
            acc_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_VERTICES - 1)) state_in = vna_pkg::ST_IDLE;
         end
         vna_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  vna_pkg::REQ_WRITE: begin
                     if (vi_ok) begin
                        pos_we    = 1'b1;
                        acc_we    = 1'b1;
                        acc_waddr = vi32[AW-1:0];
                        acc_wdata = '0;
                     end
                  end
                  vna_pkg::REQ_FACE: begin
                     cor_in[0] = ca32[AW-1:0];
                     cor_in[1] = cb32[AW-1:0];
                     cor_in[2] = cc32[AW-1:0];
                     if (face_ok) state_in = vna_pkg::ST_FB;
                  end
                  vna_pkg::REQ_READ: begin
                     if (vi_ok) begin
                        state_in = vna_pkg::ST_RCHK;
                     end else begin
                        pend_in     = '0;
                        pend_deg_in = 1'b1;
                        state_in    = vna_pkg::ST_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         vna_pkg::ST_FB: begin
            pos_raddr = cor_ff[1];
            pa_in     = pos_rd_ff;
            state_in  = vna_pkg::ST_FC;
         end
         vna_pkg::ST_FC: begin
            pos_raddr = cor_ff[2];
            pb_in     = pos_rd_ff;
            state_in  = vna_pkg::ST_DIFF;
         end
         vna_pkg::ST_DIFF: begin
            for (int k = 0; k < 3; k++) begin
               u_in[k] = DW'($signed(pa_ff[k*CW +: CW])) - DW'($signed(pb_ff[k*CW +: CW]));
               v_in[k] = DW'($signed(pa_ff[k*CW +: CW])) -
                         DW'($signed(pos_rd_ff[k*CW +: CW]));
            end
            sel_in   = 2'd0;
            state_in = vna_pkg::ST_MUL;
         end
         vna_pkg::ST_MUL: begin
            p1_in    = PW'(u_ff[mi]) * PW'(v_ff[mj]);
            p2_in    = PW'(u_ff[mj]) * PW'(v_ff[mi]);
            state_in = vna_pkg::ST_SUB;
         end
         vna_pkg::ST_SUB: begin
            n_in[sel_ff] = NW'(p1_ff) - NW'(p2_ff);
            if (sel_ff == 2'd2) begin
               sel_in   = 2'd0;
               state_in = vna_pkg::ST_ARD;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = vna_pkg::ST_MUL;
            end
         end
         vna_pkg::ST_ARD: begin
            acc_raddr = cor_ff[sel_ff];
            state_in  = vna_pkg::ST_AWR;
         end
         vna_pkg::ST_AWR: begin
            // write lands before the next read, so repeated corners chain
            acc_we = 1'b1;
            if (sel_ff == 2'd2) begin
               state_in = vna_pkg::ST_IDLE;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = vna_pkg::ST_ARD;
            end
         end
         vna_pkg::ST_RCHK: begin
            if (acc_rd_ff == '0) begin
               pend_in     = '0;
               pend_deg_in = 1'b1;
               state_in    = vna_pkg::ST_OUT;
            end else begin
               norm_start = 1'b1;
               state_in   = vna_pkg::ST_NORM;
            end
         end
         vna_pkg::ST_NORM: begin
            if (norm_done) begin
               pend_in     = norm_res;
               pend_deg_in = 1'b0;
               state_in    = vna_pkg::ST_OUT;
            end
         end
         vna_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               res_in       = pend_ff;
               res_deg_in   = pend_deg_ff;
               rsp_valid_in = 1'b1;
               state_in     = vna_pkg::ST_IDLE;
            end
         end
         default: state_in = vna_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = res_ff.x;
   assign rsp_normal_y   = res_ff.y;
   assign rsp_normal_z   = res_ff.z;
   assign rsp_degenerate = res_deg_ff;

endmodule

### test/testbench.sv
module testbench;

   localparam int  NUM_VERTS   = 1024;
   localparam int  CYCLE_LIMIT = 900000;
   localparam logic [1:0] REQ_NONE = 2'd3;

   // one input item as it goes onto the req channel
   typedef struct {
      logic [1:0]         kind;
      logic [9:0]         vertex;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
      logic [9:0]         ca;
      logic [9:0]         cb;
      logic [9:0]         cc;
   } mesh_item_type;

   typedef struct {
      vna_pkg::normal_type n;
      logic                degen;
   } unit_normal_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = REQ_NONE;
   logic [9:0]         req_vertex_index = '0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic signed [15:0] req_pos_z = '0;
   logic [9:0]         req_corner_a = '0;
   logic [9:0]         req_corner_b = '0;
   logic [9:0]         req_corner_c = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic               rsp_degenerate;

   // predictor state: positions and 40-bit accumulators per vertex
   int     pos_store [NUM_VERTS][3];
   longint acc_store [NUM_VERTS][3];
   bit     was_written [NUM_VERTS];
   int     written_list [$];

   unit_normal_type pending_normals [$];

   int  mismatches = 0;
   int  cycles = 0;
   int  items_sent = 0;
   bit  sender_gaps = 1'b1;
   bit  receiver_gaps = 1'b1;
   int  hold_left = 0;

   mesh_vertex_normal_accumulator_unit dut (.*);

   always #10 clock = ~clock;

   // generous run limit: covers ~1400 items plus stalls
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("mesh_vertex_normal_accumulator_unit verification failed");
         $finish;
      end
   end

   // receiver: random stall bursts, plus a long hold-off on request
   int stall_burst = 0;
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_burst > 0) begin
         stall_burst <= stall_burst - 1;
         rsp_stall <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
         stall_burst <= $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
   endtask

   // result checker: every accepted result against the oldest expected normal
   always @(posedge clock) begin
      unit_normal_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_normals.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = pending_normals.pop_front();
            if (rsp_normal_x !== want.n.x)
               report_mismatch("normal_x", longint'(rsp_normal_x), longint'(want.n.x));
            if (rsp_normal_y !== want.n.y)
               report_mismatch("normal_y", longint'(rsp_normal_y), longint'(want.n.y));
            if (rsp_normal_z !== want.n.z)
               report_mismatch("normal_z", longint'(rsp_normal_z), longint'(want.n.z));
            if (rsp_degenerate !== want.degen)
               report_mismatch("degenerate", longint'(rsp_degenerate), longint'(want.degen));
         end
      end
   end

   function automatic longint sat40(input longint s);
      longint hi;
      hi = (longint'(1) <<< 39) - 1;
      if (s > hi) return hi;
      if (s < -hi - 1) return -hi - 1;
      return s;
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // unit-length normal of one accumulator, Q1.14
   function automatic unit_normal_type unit_normal(input int v);
      unit_normal_type res;
      longint unsigned mag [3];
      longint unsigned m, s, len, q;
      longint sv;
      res.n = '0;
      res.degen = 1'b1;
      if (acc_store[v][0] == 0 && acc_store[v][1] == 0 && acc_store[v][2] == 0) return res;
      m = 0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = acc_store[v][k] < 0 ? -acc_store[v][k] : acc_store[v][k];
         if (mag[k] > m) m = mag[k];
      end
      while (m >= (64'd1 << 31)) begin
         for (int k = 0; k < 3; k++) mag[k] >>= 1;
         m >>= 1;
      end
      while (m < (64'd1 << 30)) begin
         for (int k = 0; k < 3; k++) mag[k] <<= 1;
         m <<= 1;
      end
      s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      len = floor_sqrt(s);
      for (int k = 0; k < 3; k++) begin
         q = (mag[k] * 16384 + (len >> 1)) / len;
         sv = acc_store[v][k] < 0 ? -longint'(q) : longint'(q);
         if (k == 0) res.n.x = sv[15:0];
         else if (k == 1) res.n.y = sv[15:0];
         else res.n.z = sv[15:0];
      end
      res.degen = 1'b0;
      return res;
   endfunction

   // update the predicted state for one accepted item
   function automatic void predict(input mesh_item_type it);
      longint u [3], w [3], n [3];
      int corner [3];
      case (it.kind)
         vna_pkg::REQ_WRITE: begin
            pos_store[it.vertex][0] = int'(it.px);
            pos_store[it.vertex][1] = int'(it.py);
            pos_store[it.vertex][2] = int'(it.pz);
            for (int k = 0; k < 3; k++) acc_store[it.vertex][k] = 0;
            if (!was_written[it.vertex])
               written_list.insert(written_list.size(), int'(it.vertex));
            was_written[it.vertex] = 1'b1;
         end
         vna_pkg::REQ_FACE: begin
            corner[0] = int'(it.ca);
            corner[1] = int'(it.cb);
            corner[2] = int'(it.cc);
            for (int k = 0; k < 3; k++) begin
               u[k] = longint'(pos_store[it.ca][k]) - pos_store[it.cb][k];
               w[k] = longint'(pos_store[it.ca][k]) - pos_store[it.cc][k];
            end
            n[0] = u[1] * w[2] - u[2] * w[1];
            n[1] = u[2] * w[0] - u[0] * w[2];
            n[2] = u[0] * w[1] - u[1] * w[0];
            // corners in order a, b, c; repeated corners add twice
            for (int j = 0; j < 3; j++)
               for (int k = 0; k < 3; k++)
                  acc_store[corner[j]][k] = sat40(acc_store[corner[j]][k] + n[k]);
         end
         vna_pkg::REQ_READ:
            pending_normals.insert(pending_normals.size(), unit_normal(int'(it.vertex)));
         default: ;
      endcase
   endfunction

   // drive one item and hold it until it is taken; valid stays high afterwards
   task automatic send_item(input mesh_item_type it);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= it.kind;
      req_vertex_index <= it.vertex;
      req_pos_x        <= it.px;
      req_pos_y        <= it.py;
      req_pos_z        <= it.pz;
      req_corner_a     <= it.ca;
      req_corner_b     <= it.cb;
      req_corner_c     <= it.cc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict(it);
      if (it.kind != REQ_NONE) items_sent++;
   endtask

   function automatic mesh_item_type noise_fields();
      mesh_item_type it;
      it.kind   = REQ_NONE;
      it.vertex = 10'($urandom);
      it.px     = 16'($urandom);
      it.py     = 16'($urandom);
      it.pz     = 16'($urandom);
      it.ca     = 10'($urandom);
      it.cb     = 10'($urandom);
      it.cc     = 10'($urandom);
      return it;
   endfunction

   task automatic write_vertex(input int v, input int x, input int y, input int z);
      mesh_item_type it;
      it = noise_fields();
      it.kind = vna_pkg::REQ_WRITE;
      it.vertex = 10'(v);
      it.px = 16'(x);
      it.py = 16'(y);
      it.pz = 16'(z);
      send_item(it);
   endtask

   task automatic add_face(input int a, input int b, input int c);
      mesh_item_type it;
      it = noise_fields();
      it.kind = vna_pkg::REQ_FACE;
      it.ca = 10'(a);
      it.cb = 10'(b);
      it.cc = 10'(c);
      send_item(it);
   endtask

   task automatic read_normal(input int v);
      mesh_item_type it;
      it = noise_fields();
      it.kind = vna_pkg::REQ_READ;
      it.vertex = 10'(v);
      send_item(it);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_normals.size() != 0) @(posedge clock);
   endtask

   // extreme coordinates, every request kind, zero and degenerate cases
   task automatic test_directed();
      read_normal(500);                          // never touched: zero accumulator
      write_vertex(0, 32767, -32768, 0);
      write_vertex(1, -32768, 32767, 32767);
      write_vertex(1023, 0, 0, -32768);
      read_normal(0);                            // just written: still zero
      add_face(0, 1, 1023);
      read_normal(0);
      read_normal(1);
      read_normal(1023);
      add_face(0, 0, 1);                         // repeated corner: zero normal
      send_item(noise_fields());                 // unknown request, no result
      write_vertex(2, 1, 0, 0);
      write_vertex(3, 0, 1, 0);
      write_vertex(4, 0, 0, 0);
      add_face(4, 2, 3);                         // smallest non-zero normal
      read_normal(4);
      add_face(4, 3, 2);                         // cancels back to zero
      read_normal(2);
      write_vertex(0, -1, -1, -1);
      read_normal(0);
      read_normal(1023);
      wait_drained();
   endtask

   // many large faces drive the accumulators into both saturation limits
   task automatic test_saturation();
      write_vertex(10, 32767, -32768, 32767);
      write_vertex(11, -32768, 32767, 32767);
      write_vertex(12, -32768, -32768, -32768);
      for (int i = 0; i < 140; i++) add_face(10, 11, 12);
      read_normal(10);
      read_normal(12);
      write_vertex(10, 32767, -32768, 32767);
      for (int i = 0; i < 140; i++) add_face(10, 12, 11);
      read_normal(10);
      read_normal(11);
      wait_drained();
   endtask

   // receiver holds off for a long stretch while reads keep coming
   task automatic test_backpressure();
      hold_left = 400;
      for (int i = 0; i < 8; i++) begin
         read_normal(i % 2 ? 11 : 12);
         add_face(10, 11, 12);
      end
      wait_drained();                            // sender pauses until all came back
   endtask

   function automatic int rand_coord();
      if ($urandom_range(0, 3) == 0) return int'($signed(16'($urandom)));
      return $signed(16'($urandom_range(0, 4095))) - 2048;
   endfunction

   // mostly well-formed patches: write a few vertices, add faces among them, read; else one random item
   task automatic test_random_mesh(input int target);
      int patch [$];
      int v;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: send_item(noise_fields());
               1: read_normal($urandom_range(0, NUM_VERTS - 1));
               2: write_vertex($urandom_range(0, NUM_VERTS - 1), rand_coord(), rand_coord(),
                               rand_coord());
               default: add_face(written_list[$urandom_range(0, written_list.size() - 1)],
                                 written_list[$urandom_range(0, written_list.size() - 1)],
                                 written_list[$urandom_range(0, written_list.size() - 1)]);
            endcase
         end else begin
            patch.delete();
            repeat ($urandom_range(3, 6)) begin
               v = $urandom_range(0, NUM_VERTS - 1);
               patch.insert(patch.size(), v);
               write_vertex(v, rand_coord(), rand_coord(), rand_coord());
            end
            repeat ($urandom_range(1, 8))
               add_face(patch[$urandom_range(0, patch.size() - 1)],
                        patch[$urandom_range(0, patch.size() - 1)],
                        patch[$urandom_range(0, patch.size() - 1)]);
            repeat ($urandom_range(1, 3)) read_normal(patch[$urandom_range(0, patch.size() - 1)]);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_saturation();
      test_backpressure();
      test_random_mesh(1200);
      // quiet tail: no idling on either side
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      test_random_mesh(1400);
      wait_drained();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && pending_normals.size() == 0) begin
         $display("mesh_vertex_normal_accumulator_unit verification clean");
      end else begin
         $display("mesh_vertex_normal_accumulator_unit verification failed");
      end
      $finish;
   end

endmodule
